FILE: sv/sdf_pkg.sv
// sdf_pkg: types, constants and state codes for the signed decimal formatter
// used by sdf_digit_cell and signed_decimal_formatter_core; no dependencies
package sdf_pkg;

  // input beat: one signed value with its printf-style flags
  typedef struct packed {
    logic signed [31:0] value;
    logic               space_flag;
    logic               plus_flag;
    logic               zero_flag;
    logic               dot_flag;
    logic               precision_is_zero;
    logic [5:0]         pad_zeros;
  } sdf_in_t;

  // output beat: one character with the running printed count
  typedef struct packed {
    logic [6:0]  character;
    logic        last_char;
    logic [31:0] count_after;
  } sdf_out_t;

  // controls shared by every digit cell of the chain
  typedef struct packed {
    logic clear;      // zero the digit at the start of a value
    logic bit_shift;  // double-dabble step: correct, shift in one binary bit
    logic dig_shift;  // move each digit one cell up toward the output end
  } sdf_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_EMIT
  } sdf_state_t;

  localparam int MAG_W      = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int PAD_LIMIT  = 48;   // keeps any value within 60 characters
  localparam int MAX_PAD_DEFAULT = 48;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;

endpackage

FILE: sv/sdf_digit_cell.sv
// sdf_digit_cell: one BCD digit of the binary-to-decimal chain
// depends on sdf_pkg for the cell control struct and digit width
module sdf_digit_cell (
  input  logic                   clk,
  input  sdf_pkg::sdf_cell_ctrl_t ctrl,
  input  logic                   bit_in,
  output logic                   bit_out,
  input  logic [3:0]             dig_in,
  output logic [3:0]             digit
);
  import sdf_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] corr;

  // add three to digits of five and up before the shift
  assign corr    = (digit_r >= DIGIT_W'(5)) ? (digit_r + DIGIT_W'(3)) : digit_r;
  assign bit_out = corr[DIGIT_W-1];
  assign digit   = digit_r;

  always_comb begin
    priority if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.bit_shift) begin
      digit_nxt = {corr[DIGIT_W-2:0], bit_in};
    end else if (ctrl.dig_shift) begin
      digit_nxt = dig_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  // digit storage, cleared by ctrl.clear at each new value
  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

FILE: sv/signed_decimal_formatter_core.sv
// Signed decimal formatter. One input beat carries a signed 32-bit value and
// printf-style flags; the block returns its decimal text one character per
// output beat, sign first, then any zero padding, then the digits with no
// leading zeros, the last character flagged and each beat carrying the
// running printed-character count. Zero with a zero precision returns no
// beats. A value is accepted, then converted by double dabble (one magnitude bit
// per cycle through a chain of ten BCD digit cells), then its leading zeros are
// dropped one at a time, always keeping the units digit, and then its characters
// are emitted as the output side takes beats. A new value is accepted once the
// last character of the previous one sits in the output register.
// depends on sdf_pkg and sdf_digit_cell
module signed_decimal_formatter_core #(
  parameter int MAX_PAD = sdf_pkg::MAX_PAD_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdf_pkg::sdf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sdf_pkg::sdf_out_t out_data
);
  import sdf_pkg::*;

  localparam int PadCap  = (MAX_PAD < PAD_LIMIT) ? MAX_PAD : PAD_LIMIT;
  localparam int PadW    = (PadCap < 1) ? 1 : $clog2(PadCap + 1);
  localparam int BitCntW = $clog2(MAG_W);
  localparam int DigCntW = $clog2(NUM_DIGITS + 1);

  sdf_state_t state_r, state_nxt;

  logic [BitCntW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [DigCntW-1:0] ndig_r, ndig_nxt;
  logic               space_pend_r, space_pend_nxt;
  logic               plus_pend_r, plus_pend_nxt;
  logic               minus_pend_r, minus_pend_nxt;
  logic [PadW-1:0]    pad_cnt_r, pad_cnt_nxt;
  logic [31:0]        count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  sdf_out_t           out_data_r, out_data_nxt;

  logic               in_fire;
  logic               suppress;
  logic               neg;
  logic [MAG_W-1:0]   raw;
  logic               load;
  logic               top_zero;
  logic               emit_digit;
  logic [PadW-1:0]    pad_start;
  sdf_cell_ctrl_t     cell_ctrl;

  logic [NUM_DIGITS:0]     carry;
  logic [DIGIT_W-1:0]      digits [NUM_DIGITS];
  logic [DIGIT_W-1:0]      dig_feed [NUM_DIGITS];

  // input side decode
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign raw      = in_data.value;
  assign neg      = raw[MAG_W-1];
  assign suppress = (raw == '0) && in_data.dot_flag && in_data.precision_is_zero;

  // zero padding, capped so no value exceeds the character limit
  always_comb begin
    if (!in_data.zero_flag) begin
      pad_start = '0;
    end else if (int'(in_data.pad_zeros) > PadCap) begin
      pad_start = PadW'(PadCap);
    end else begin
      pad_start = PadW'(in_data.pad_zeros);
    end
  end

  assign load       = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign top_zero   = (digits[NUM_DIGITS-1] == '0);
  assign emit_digit = load && !space_pend_r && !plus_pend_r && !minus_pend_r &&
                      (pad_cnt_r == '0);

  // chain of digit cells, binary bits enter at the low end
  assign carry[0] = mag_r[MAG_W-1];

  genvar gi;
  generate
    for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign dig_feed[gi] = '0;
      end else begin : g_rest
        assign dig_feed[gi] = digits[gi-1];
      end
      sdf_digit_cell u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .bit_in  (carry[gi]),
        .bit_out (carry[gi+1]),
        .dig_in  (dig_feed[gi]),
        .digit   (digits[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !suppress) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_r == BitCntW'(MAG_W - 1)) state_nxt = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (!(top_zero && (ndig_r > DigCntW'(1)))) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_digit && (ndig_r == DigCntW'(1))) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output control
  always_comb begin
    bit_cnt_nxt    = bit_cnt_r;
    mag_nxt        = mag_r;
    ndig_nxt       = ndig_r;
    space_pend_nxt = space_pend_r;
    plus_pend_nxt  = plus_pend_r;
    minus_pend_nxt = minus_pend_r;
    pad_cnt_nxt    = pad_cnt_r;
    count_nxt      = count_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    cell_ctrl      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cell_ctrl.clear = 1'b1;
          bit_cnt_nxt     = '0;
          mag_nxt         = neg ? (~raw + MAG_W'(1)) : raw;
          ndig_nxt        = DigCntW'(NUM_DIGITS);
          space_pend_nxt  = !neg && in_data.space_flag;
          plus_pend_nxt   = !neg && in_data.plus_flag;
          minus_pend_nxt  = neg;
          pad_cnt_nxt     = pad_start;
        end
      end
      ST_CONV: begin
        cell_ctrl.bit_shift = 1'b1;
        mag_nxt             = {mag_r[MAG_W-2:0], 1'b0};
        bit_cnt_nxt         = bit_cnt_r + BitCntW'(1);
      end
      ST_ALIGN: begin
        // drop leading zeros, always keep the units digit
        if (top_zero && (ndig_r > DigCntW'(1))) begin
          cell_ctrl.dig_shift = 1'b1;
          ndig_nxt            = ndig_r - DigCntW'(1);
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt            = 1'b1;
          count_nxt                = count_r + 32'd1;
          out_data_nxt.count_after = count_r + 32'd1;
          out_data_nxt.last_char   = 1'b0;
          priority if (space_pend_r) begin
            out_data_nxt.character = CH_SPACE;
            space_pend_nxt         = 1'b0;
          end else if (plus_pend_r) begin
            out_data_nxt.character = CH_PLUS;
            plus_pend_nxt          = 1'b0;
          end else if (minus_pend_r) begin
            out_data_nxt.character = CH_MINUS;
            minus_pend_nxt         = 1'b0;
          end else if (pad_cnt_r != '0) begin
            out_data_nxt.character = CH_ZERO;
            pad_cnt_nxt            = pad_cnt_r - PadW'(1);
          end else begin
            out_data_nxt.character = CH_ZERO + {3'b000, digits[NUM_DIGITS-1]};
            out_data_nxt.last_char = (ndig_r == DigCntW'(1));
            cell_ctrl.dig_shift    = 1'b1;
            ndig_nxt               = ndig_r - DigCntW'(1);
          end
        end
      end
      default: begin
        cell_ctrl = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // working registers, loaded on every accepted value
  always_ff @(posedge clk) begin
    bit_cnt_r    <= bit_cnt_nxt;
    mag_r        <= mag_nxt;
    ndig_r       <= ndig_nxt;
    space_pend_r <= space_pend_nxt;
    plus_pend_r  <= plus_pend_nxt;
    minus_pend_r <= minus_pend_nxt;
    pad_cnt_r    <= pad_cnt_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: bench/tb_signed_decimal_formatter_core.sv
// tb_signed_decimal_formatter_core: randomized self-checking bench for the signed
// decimal formatter, with a bursty sender, a stalling receiver and a scoreboard
// depends on sdf_pkg and signed_decimal_formatter_core
`timescale 1ns / 1ps

module tb_signed_decimal_formatter_core;
  import sdf_pkg::*;

  localparam int RANDOM_VALUES = 188;
  localparam int DRAIN_CYCLES  = 80;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sdf_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sdf_out_t out_data;

  // values waiting to be sent, and characters waiting to come back
  sdf_in_t  pending_values[$];
  sdf_out_t expected_text[$];
  logic [31:0] char_total;
  int          mismatches;

  // sender and receiver pacing
  logic in_taken;
  int   burst_left;
  int   gap_left;
  int   ready_mode;
  int   ready_phase;

  signed_decimal_formatter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // queue one expected character and advance the printed count
  task automatic push_char(input logic [6:0] ch, input logic is_last);
    sdf_out_t beat;
    char_total        = char_total + 32'd1;
    beat.character    = ch;
    beat.last_char    = is_last;
    beat.count_after  = char_total;
    expected_text.push_back(beat);
  endtask

  // work out the text of one value: sign, zero padding, then digits
  task automatic format_value(input sdf_in_t item);
    logic [31:0] raw;
    logic [31:0] mag;
    logic [3:0]  digs[10];
    int          nd;
    int          npad;
    raw = item.value;
    nd  = 0;
    if (raw == 32'd0 && item.dot_flag && item.precision_is_zero) return;
    if (raw[31]) begin
      push_char(CH_MINUS, 1'b0);
      mag = 32'd0 - raw;
    end else begin
      if (item.space_flag) push_char(CH_SPACE, 1'b0);
      if (item.plus_flag) push_char(CH_PLUS, 1'b0);
      mag = raw;
    end
    if (item.zero_flag) begin
      npad = int'(item.pad_zeros);
      if (npad > PAD_LIMIT) npad = PAD_LIMIT;
      for (int i = 0; i < npad; i++) push_char(CH_ZERO, 1'b0);
    end
    // least significant digit first, printed in reverse
    do begin
      digs[nd] = 4'(mag % 32'd10);
      nd++;
      mag = mag / 32'd10;
    end while (mag != 32'd0 && nd < 10);
    for (int i = nd - 1; i >= 0; i--) push_char(CH_ZERO + 7'(digs[i]), i == 0);
  endtask

  function automatic sdf_in_t make_value(input logic [31:0] v, input int sp,
                                         input int pl, input int zf,
                                         input int df, input int pz,
                                         input logic [5:0] pad);
    sdf_in_t item;
    item.value             = v;
    item.space_flag        = 1'(sp);
    item.plus_flag         = 1'(pl);
    item.zero_flag         = 1'(zf);
    item.dot_flag          = 1'(df);
    item.precision_is_zero = 1'(pz);
    item.pad_zeros         = pad;
    return item;
  endfunction

  // random value drawn from a mix of widths and edge values
  function automatic logic [31:0] pick_value();
    logic [31:0] edges[10];
    edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd999999999,
              32'd1000000000, -32'sd1000000000, 32'd9, 32'd10, -32'sd10};
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4:    return 32'($signed($urandom_range(0, 199)) - 100);
      5:       return 32'd0;
      6:       return edges[$urandom_range(0, 9)];
      default: return $signed($urandom()) >>> $urandom_range(1, 31);
    endcase
  endfunction

  // stimulus: directed corner cases, then random values
  initial begin
    logic       zf;
    logic [5:0] pad;
    in_valid = 1'b0;
    in_data  = '0;
    out_ready = 1'b0;
    rst_n = 1'b0;

    // zero and the empty-output case
    pending_values.push_back(make_value(32'd0, 0, 0, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'd0, 0, 0, 0, 1, 1, 6'd0));
    pending_values.push_back(make_value(32'd0, 1, 1, 1, 1, 1, 6'd5));
    pending_values.push_back(make_value(32'd0, 0, 0, 0, 1, 0, 6'd0));
    pending_values.push_back(make_value(32'd0, 0, 0, 0, 0, 1, 6'd0));
    // extremes of the value
    pending_values.push_back(make_value(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'h8000_0000, 0, 0, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'h8000_0000, 1, 1, 1, 1, 1, 6'd63));
    pending_values.push_back(make_value(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'd1, 0, 0, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'd9, 0, 0, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'd10, 0, 0, 0, 0, 0, 6'd0));
    // sign flags on positive and negative values
    pending_values.push_back(make_value(32'd123, 1, 0, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'd123, 0, 1, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'd123, 1, 1, 0, 0, 0, 6'd0));
    pending_values.push_back(make_value(-32'sd123, 1, 1, 0, 0, 0, 6'd0));
    // zero padding: none, full, beyond the cap, and disabled
    pending_values.push_back(make_value(32'd7, 0, 0, 1, 0, 0, 6'd0));
    pending_values.push_back(make_value(32'd7, 0, 1, 1, 0, 0, 6'd48));
    pending_values.push_back(make_value(-32'sd7, 0, 0, 1, 0, 0, 6'd49));
    pending_values.push_back(make_value(32'h7FFF_FFFF, 1, 1, 1, 0, 0, 6'd63));
    pending_values.push_back(make_value(32'd42, 0, 0, 0, 0, 0, 6'd63));
    pending_values.push_back(make_value(32'd5, 0, 0, 1, 1, 1, 6'd3));

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      zf  = ($urandom_range(0, 2) == 0);
      pad = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, 6));
      pending_values.push_back(make_value(pick_value(), $urandom_range(0, 1),
                                          $urandom_range(0, 1), zf,
                                          $urandom_range(0, 1),
                                          $urandom_range(0, 1), pad));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: all values sent, all characters back, then a quiet spell
    wait (rst_n && pending_values.size() == 0 && !in_valid);
    wait (expected_text.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0)
      $display("[signed_decimal_formatter_core] OK");
    else
      $display("[signed_decimal_formatter_core] ERROR");
    $finish;
  end

  // sender: bursts of values separated by random gaps
  initial begin
    burst_left = 1;
    gap_left   = 0;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_values.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_values.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 10);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches to a randomly chosen mode each time the phase counter wraps
  initial begin
    ready_mode  = 0;
    ready_phase = 0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_phase == 47) begin
        ready_phase <= 0;
        ready_mode  <= $urandom_range(0, 3);
      end else begin
        ready_phase <= ready_phase + 1;
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (ready_phase % 5 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor: predict on each input beat, check each output beat
  initial begin
    char_total = '0;
    mismatches = 0;
    in_taken   = 1'b0;
  end

  always @(posedge clk) begin : monitor
    sdf_out_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) format_value(in_data);
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat expected none actual char=%h last=%b count=%0d",
                   $time, out_data.character, out_data.last_char,
                   out_data.count_after);
        end else begin
          want = expected_text.pop_front();
          if (out_data.character !== want.character) begin
            mismatches++;
            $display("%0t: character expected %h actual %h", $time,
                     want.character, out_data.character);
          end
          if (out_data.last_char !== want.last_char) begin
            mismatches++;
            $display("%0t: last_char expected %b actual %b", $time,
                     want.last_char, out_data.last_char);
          end
          if (out_data.count_after !== want.count_after) begin
            mismatches++;
            $display("%0t: count_after expected %0d actual %0d", $time,
                     want.count_after, out_data.count_after);
          end
        end
      end
    end
  end

  // watchdog well past the slowest legal run
  initial begin
    #8ms;
    $display("[signed_decimal_formatter_core] ERROR");
    $finish;
  end

endmodule
